>>> sv/vdh_pkg.sv
// ----------------------------------------------------------------------------
// vdh_pkg
// Shared types and constants for the vertex de-duplication hash table.
// ----------------------------------------------------------------------------
`default_nettype none

package vdh_pkg;

   // Table size must stay a power of two: the start slot is the low hash bits
   localparam int TABLE_ENTRIES = 4096;
   localparam int IDX_W         = $clog2(TABLE_ENTRIES);
   localparam int REF_W         = 16;
   localparam int KEY_W         = 3 * REF_W;
   localparam int VTX_W         = REF_W + 1;
   localparam logic [VTX_W-1:0] INDEX_SPACE = VTX_W'(1) << REF_W;

   typedef struct packed {
      logic             mode;
      logic [REF_W-1:0] pos_ref;
      logic [REF_W-1:0] uv_ref;
      logic [REF_W-1:0] normal_ref;
   } req_type;

   typedef struct packed {
      logic [REF_W-1:0] vertex_index;
      logic             is_new;
      logic [REF_W-1:0] pos_index;
      logic [REF_W-1:0] uv_index;
      logic [REF_W-1:0] normal_index;
      logic             table_full;
   } rsp_type;

   typedef enum logic [2:0] {
      RSP_NONE,
      RSP_CLEAR,
      RSP_HIT,
      RSP_NEW,
      RSP_FULL
   } rsp_kind_type;

   // controller -> datapath
   typedef struct packed {
      logic         load;      // latch request, read start slot
      logic         probe;     // advance to next slot and read it
      logic         insert;    // write new entry at current slot
      logic         wipe;      // invalidate entry at wipe pointer
      logic         wipe_end;  // last wipe write: reset vertex counter
      rsp_kind_type rsp;
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic slot_valid;
      logic key_match;
      logic probe_last;
      logic space_ok;
      logic wipe_last;
   } sts_type;

endpackage

`default_nettype wire

>>> sv/vertex_dedup_hash_table_top.sv
// ----------------------------------------------------------------------------
// vertex_dedup_hash_table_top
// Turns face-corner reference triples into de-duplicated vertex indices.
// ----------------------------------------------------------------------------
// Usage:
//   A request (req_data) is taken on a rising edge with start high and busy
//   low. mode 0 looks up the zero-based triple in a 4096-slot linear-probed
//   hash table, inserting a new vertex number on a miss; mode 1 clears the
//   table and the vertex counter.
//   Each request gives exactly one response on rsp_data, shown for a single
//   cycle with rsp_valid high. The receiver cannot stall; there is no hold.
//   The start slot is read into a register at the accept edge, the check
//   state decides on it and the response register raises the strobe; each
//   extra probe adds one slot memory read (one slot read per cycle). busy
//   drops together with the strobe, so no new request is taken before it.
//   A clear walks the slot memory one entry per cycle and responds with the
//   write of the last entry.
//   After reset the same clearing pass runs with busy high and no response.
// ----------------------------------------------------------------------------
`default_nettype none

module vertex_dedup_hash_table_top (
   input  wire              clock,
   input  wire              reset,
   input  wire              start,
   output logic             busy,
   input  vdh_pkg::req_type req_data,
   output logic             rsp_valid,
   output vdh_pkg::rsp_type rsp_data
);

   vdh_pkg::cmd_type cmd;
   vdh_pkg::sts_type sts;

   vdh_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .req_mode (req_data.mode),
      .sts      (sts),
      .cmd      (cmd),
      .busy     (busy)
   );

   vdh_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .cmd       (cmd),
      .sts       (sts),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

endmodule

`default_nettype wire

>>> sv/vdh_datapath.sv
// ----------------------------------------------------------------------------
// vdh_datapath
// Slot memory, key and probe registers, vertex counter and response register.
// ----------------------------------------------------------------------------
`default_nettype none

module vdh_datapath (
   input  wire              clock,
   input  wire              reset,
   input  vdh_pkg::req_type req_data,
   input  vdh_pkg::cmd_type cmd,
   output vdh_pkg::sts_type sts,
   output logic             rsp_valid,
   output vdh_pkg::rsp_type rsp_data
);

   typedef struct packed {
      logic                      valid;
      logic [vdh_pkg::KEY_W-1:0] key;
      logic [vdh_pkg::REF_W-1:0] value;
   } entry_type;

   entry_type slot_mem [vdh_pkg::TABLE_ENTRIES];

   entry_type                  rd_data_ff;
   logic [vdh_pkg::IDX_W-1:0]  rd_addr;
   logic                       wr_en;
   logic [vdh_pkg::IDX_W-1:0]  wr_addr;
   entry_type                  wr_data;

   logic [vdh_pkg::REF_W-1:0]  p_in, t_in, n_in;
   logic [vdh_pkg::KEY_W-1:0]  key_ff, key_in;
   logic [vdh_pkg::IDX_W-1:0]  slot_ff, slot_in, start_slot, slot_next;
   logic [vdh_pkg::IDX_W-1:0]  probe_ff, probe_in;
   logic [vdh_pkg::IDX_W-1:0]  wipe_ff, wipe_in;
   logic [vdh_pkg::VTX_W-1:0]  next_vertex_ff, next_vertex_in;
   vdh_pkg::rsp_type           rsp_ff, rsp_in;
   logic                       rsp_valid_ff, rsp_valid_in;

   function automatic logic [vdh_pkg::IDX_W-1:0] slot_hash(
      input logic [vdh_pkg::REF_W-1:0] p,
      input logic [vdh_pkg::REF_W-1:0] t,
      input logic [vdh_pkg::REF_W-1:0] n
   );
      logic [38:0] h;
      h = {23'd0, p} ^ {9'd0, t, 14'd0} ^ {n, 23'd0};
      return h[vdh_pkg::IDX_W-1:0];
   endfunction

   assign p_in       = req_data.pos_ref    - 16'd1;
   assign t_in       = req_data.uv_ref     - 16'd1;
   assign n_in       = req_data.normal_ref - 16'd1;
   assign start_slot = slot_hash(p_in, t_in, n_in);
   assign slot_next  = slot_ff + 1'b1;

   assign rd_addr = cmd.load ? start_slot : slot_next;

   always_comb begin
      wr_en   = cmd.insert | cmd.wipe;
      wr_addr = cmd.wipe ? wipe_ff : slot_ff;
      wr_data = '0;
      if (cmd.insert) begin
         wr_data.valid = 1'b1;
         wr_data.key   = key_ff;
         wr_data.value = next_vertex_ff[vdh_pkg::REF_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         slot_mem[wr_addr] <= wr_data;
      end
      if (cmd.load | cmd.probe) begin
         rd_data_ff <= slot_mem[rd_addr];
      end
   end

   // status
   assign sts.slot_valid = rd_data_ff.valid;
   assign sts.key_match  = (rd_data_ff.key == key_ff);
   assign sts.probe_last = (probe_ff == vdh_pkg::IDX_W'(vdh_pkg::TABLE_ENTRIES - 1));
   assign sts.space_ok   = (next_vertex_ff < vdh_pkg::INDEX_SPACE);
   assign sts.wipe_last  = (wipe_ff == vdh_pkg::IDX_W'(vdh_pkg::TABLE_ENTRIES - 1));

   always_comb begin
      key_in         = key_ff;
      slot_in        = slot_ff;
      probe_in       = probe_ff;
      wipe_in        = wipe_ff;
      next_vertex_in = next_vertex_ff;

      if (cmd.load) begin
         key_in   = {n_in, t_in, p_in};
         slot_in  = start_slot;
         probe_in = '0;
      end
      if (cmd.probe) begin
         slot_in  = slot_next;
         probe_in = probe_ff + 1'b1;
      end
      // pointer wraps back to zero after the last entry
      if (cmd.wipe) begin
         wipe_in = wipe_ff + 1'b1;
      end
      if (cmd.insert) begin
         next_vertex_in = next_vertex_ff + 1'b1;
      end
      if (cmd.wipe_end) begin
         next_vertex_in = '0;
      end
   end

   always_comb begin
      rsp_in       = '0;
      rsp_valid_in = 1'b1;
      rsp_in.pos_index    = key_ff[vdh_pkg::REF_W-1:0];
      rsp_in.uv_index     = key_ff[2*vdh_pkg::REF_W-1:vdh_pkg::REF_W];
      rsp_in.normal_index = key_ff[3*vdh_pkg::REF_W-1:2*vdh_pkg::REF_W];
      unique case (cmd.rsp)
         vdh_pkg::RSP_NONE: begin
            rsp_valid_in = 1'b0;
         end
         vdh_pkg::RSP_CLEAR: begin
            rsp_in = '0;
         end
         vdh_pkg::RSP_HIT: begin
            rsp_in.vertex_index = rd_data_ff.value;
         end
         vdh_pkg::RSP_NEW: begin
            rsp_in.vertex_index = next_vertex_ff[vdh_pkg::REF_W-1:0];
            rsp_in.is_new       = 1'b1;
         end
         vdh_pkg::RSP_FULL: begin
            rsp_in.table_full = 1'b1;
         end
         default: begin
            rsp_valid_in = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      key_ff   <= key_in;
      slot_ff  <= slot_in;
      probe_ff <= probe_in;
      rsp_ff   <= rsp_in;
      if (reset) begin
         wipe_ff        <= '0;
         next_vertex_ff <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         wipe_ff        <= wipe_in;
         next_vertex_ff <= next_vertex_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

`default_nettype wire

>>> sv/vdh_ctrl.sv
// ----------------------------------------------------------------------------
// vdh_ctrl
// Sequencer: table wipe, request accept and linear probe decisions.
// ----------------------------------------------------------------------------
`default_nettype none

module vdh_ctrl (
   input  wire              clock,
   input  wire              reset,
   input  wire              start,
   input  wire              req_mode,
   input  vdh_pkg::sts_type sts,
   output vdh_pkg::cmd_type cmd,
   output logic             busy
);

   typedef enum logic [1:0] {
      ST_WIPE,
      ST_IDLE,
      ST_CHECK
   } state_type;

   state_type state_ff, state_in;
   logic      clr_rsp_ff, clr_rsp_in;
   logic      busy_ff, busy_in;

   always_comb begin
      state_in   = state_ff;
      clr_rsp_in = clr_rsp_ff;
      cmd        = '0;
      cmd.rsp    = vdh_pkg::RSP_NONE;

      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               if (req_mode) begin
                  clr_rsp_in = 1'b1;
                  state_in   = ST_WIPE;
               end else begin
                  cmd.load = 1'b1;
                  state_in = ST_CHECK;
               end
            end
         end
         ST_CHECK: begin
            if (!sts.slot_valid) begin
               state_in = ST_IDLE;
               if (sts.space_ok) begin
                  cmd.insert = 1'b1;
                  cmd.rsp    = vdh_pkg::RSP_NEW;
               end else begin
                  cmd.rsp = vdh_pkg::RSP_FULL;
               end
            end else if (sts.key_match) begin
               state_in = ST_IDLE;
               cmd.rsp  = vdh_pkg::RSP_HIT;
            end else if (sts.probe_last) begin
               // every slot occupied and none matched
               state_in = ST_IDLE;
               cmd.rsp  = vdh_pkg::RSP_FULL;
            end else begin
               cmd.probe = 1'b1;
            end
         end
         ST_WIPE: begin
            cmd.wipe = 1'b1;
            if (sts.wipe_last) begin
               cmd.wipe_end = 1'b1;
               cmd.rsp      = clr_rsp_ff ? vdh_pkg::RSP_CLEAR : vdh_pkg::RSP_NONE;
               clr_rsp_in   = 1'b0;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      busy_in = (state_in != ST_IDLE);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_WIPE;
         clr_rsp_ff <= 1'b0;
         busy_ff    <= 1'b1;
      end else begin
         state_ff   <= state_in;
         clr_rsp_ff <= clr_rsp_in;
         busy_ff    <= busy_in;
      end
   end

   assign busy = busy_ff;

endmodule

`default_nettype wire

>>> sim/tb_vertex_dedup_hash_table_top.sv
// ----------------------------------------------------------------------------
// tb_vertex_dedup_hash_table_top
// Self-checking bench for the vertex de-duplication hash table. A short table
// of hand-picked requests opens the run, a long run of keys sharing one start
// slot then builds a probe chain that wraps past the last slot, and a random
// stream of hits, slot collisions, odd references and clears follows. Every
// response is checked field by field against its typed row or the in-bench model.
// ----------------------------------------------------------------------------

module tb_vertex_dedup_hash_table_top;

   localparam logic MODE_CORNER = 1'b0;
   localparam logic MODE_CLEAR  = 1'b1;
   localparam logic TYPED       = 1'b1;
   localparam logic PREDICT     = 1'b0;

   localparam int HASH_UV_SHIFT  = 14;
   localparam int HASH_NRM_SHIFT = 23;

   localparam int RANDOM_ITEMS  = 640;
   localparam int CALM_TAIL     = 120;
   localparam int CLUSTER_ITEMS = 32;
   localparam int CLUSTER_HITS  = 10;
   localparam int MAX_PRINTS    = 40;

   // worst case: every request probes the whole table after the longest gap
   localparam longint unsigned ITEM_BOUND  = 6000;
   localparam longint unsigned CYCLE_LIMIT =
      3 * (ITEM_BOUND * (vdh_pkg::TABLE_ENTRIES + 16) + vdh_pkg::TABLE_ENTRIES + 64);

   typedef struct packed {
      vdh_pkg::req_type req;
      logic             typed;
      vdh_pkg::rsp_type rsp;
   } stim_row_type;

   localparam int NUM_ROWS = 19;
   localparam stim_row_type DIRECTED_ROWS [NUM_ROWS] = '{
      '{'{MODE_CORNER, 16'h0001, 16'h0001, 16'h0001}, TYPED,
        '{16'h0000, 1'b1, 16'h0000, 16'h0000, 16'h0000, 1'b0}},
      '{'{MODE_CORNER, 16'h0001, 16'h0001, 16'h0001}, TYPED,
        '{16'h0000, 1'b0, 16'h0000, 16'h0000, 16'h0000, 1'b0}},
      // zero references wrap to the top of the range
      '{'{MODE_CORNER, 16'h0000, 16'h0000, 16'h0000}, TYPED,
        '{16'h0001, 1'b1, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0}},
      '{'{MODE_CORNER, 16'hFFFF, 16'hFFFF, 16'hFFFF}, TYPED,
        '{16'h0002, 1'b1, 16'hFFFE, 16'hFFFE, 16'hFFFE, 1'b0}},
      '{'{MODE_CORNER, 16'h0000, 16'h0000, 16'h0000}, TYPED,
        '{16'h0001, 1'b0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0}},
      // rows on slot 0 differing in uv / normal / upper position bits, then slot 1
      '{'{MODE_CORNER, 16'h0001, 16'h0002, 16'h0001}, PREDICT, '0},
      '{'{MODE_CORNER, 16'h0001, 16'h0001, 16'h0002}, PREDICT, '0},
      '{'{MODE_CORNER, 16'h1001, 16'h0001, 16'h0001}, PREDICT, '0},
      '{'{MODE_CORNER, 16'h0001, 16'h0002, 16'h0001}, PREDICT, '0},
      '{'{MODE_CORNER, 16'h1001, 16'h0001, 16'h0001}, PREDICT, '0},
      '{'{MODE_CORNER, 16'h0002, 16'h0001, 16'h0001}, PREDICT, '0},
      // last slot already taken: probing wraps round to slot zero
      '{'{MODE_CORNER, 16'h1000, 16'h0001, 16'h0001}, PREDICT, '0},
      '{'{MODE_CORNER, 16'h2000, 16'h0001, 16'h0001}, PREDICT, '0},
      '{'{MODE_CORNER, 16'h8000, 16'h5555, 16'hAAAA}, PREDICT, '0},
      '{'{MODE_CORNER, 16'h7FFF, 16'hAAAA, 16'h5555}, PREDICT, '0},
      '{'{MODE_CLEAR,  16'h1234, 16'h5678, 16'h9ABC}, TYPED, '0},
      '{'{MODE_CORNER, 16'h0001, 16'h0001, 16'h0001}, TYPED,
        '{16'h0000, 1'b1, 16'h0000, 16'h0000, 16'h0000, 1'b0}},
      '{'{MODE_CORNER, 16'h0000, 16'h0000, 16'h0000}, TYPED,
        '{16'h0001, 1'b1, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0}},
      '{'{MODE_CLEAR,  16'h0000, 16'h0000, 16'h0000}, TYPED, '0}
   };

   logic             clock;
   logic             reset;
   logic             start;
   logic             busy;
   vdh_pkg::req_type req_data;
   logic             rsp_valid;
   vdh_pkg::rsp_type rsp_data;

   vertex_dedup_hash_table_top dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

   // model of the probing table
   logic [vdh_pkg::KEY_W-1:0] slot_key  [vdh_pkg::TABLE_ENTRIES];
   logic [vdh_pkg::REF_W-1:0] slot_vtx  [vdh_pkg::TABLE_ENTRIES];
   bit                        slot_used [vdh_pkg::TABLE_ENTRIES];
   logic [vdh_pkg::VTX_W-1:0] vtx_count;

   vdh_pkg::rsp_type pending_indices [$];
   vdh_pkg::req_type known_corners [$];

   int               err_count;
   int               idle_pct;
   int               n_req, n_new, n_hit, n_full, n_clear;
   longint           cycle_count;
   vdh_pkg::rsp_type want;

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   function automatic vdh_pkg::rsp_type resolve_corner(input vdh_pkg::req_type r);
      vdh_pkg::rsp_type          res;
      logic [vdh_pkg::REF_W-1:0] p, t, n;
      logic [vdh_pkg::KEY_W-1:0] key;
      logic [63:0]               h;
      int unsigned               slot;
      int                        k;
      bit                        found, hole;
      res   = '0;
      found = 1'b0;
      hole  = 1'b0;
      if (r.mode == MODE_CLEAR) begin
         foreach (slot_used[i]) slot_used[i] = 1'b0;
         vtx_count = '0;
         return res;
      end
      p    = r.pos_ref - 1'b1;
      t    = r.uv_ref - 1'b1;
      n    = r.normal_ref - 1'b1;
      key  = {n, t, p};
      h    = 64'(p) ^ (64'(t) << HASH_UV_SHIFT) ^ (64'(n) << HASH_NRM_SHIFT);
      slot = int'(h % 64'(vdh_pkg::TABLE_ENTRIES));
      for (k = 0; k < vdh_pkg::TABLE_ENTRIES; k++) begin
         if (!slot_used[slot]) begin
            hole = 1'b1;
            break;
         end
         if (slot_key[slot] == key) begin
            found = 1'b1;
            break;
         end
         slot = (slot + 1) % vdh_pkg::TABLE_ENTRIES;
      end
      res.pos_index    = p;
      res.uv_index     = t;
      res.normal_index = n;
      if (found) begin
         res.vertex_index = slot_vtx[slot];
      end else if (hole && vtx_count < vdh_pkg::INDEX_SPACE) begin
         slot_key[slot]   = key;
         slot_vtx[slot]   = vtx_count[vdh_pkg::REF_W-1:0];
         slot_used[slot]  = 1'b1;
         res.vertex_index = vtx_count[vdh_pkg::REF_W-1:0];
         res.is_new       = 1'b1;
         vtx_count        = vtx_count + 1'b1;
      end else begin
         res.table_full = 1'b1;
      end
      return res;
   endfunction

   task automatic report_mismatch(input string what,
                                  input logic [vdh_pkg::REF_W-1:0] got,
                                  input logic [vdh_pkg::REF_W-1:0] exp_val);
      if (err_count < MAX_PRINTS)
         $display("MISMATCH @%0d: %s got %h want %h", cycle_count, what, got, exp_val);
      err_count++;
   endtask

   // start stays high across back-to-back requests; only the idle tasks drop it
   task automatic issue(input vdh_pkg::req_type r, input logic typed,
                        input vdh_pkg::rsp_type typed_rsp);
      vdh_pkg::rsp_type res;
      start    <= 1'b1;
      req_data <= r;
      do @(posedge clock); while (busy);
      res = resolve_corner(r);
      n_req++;
      if (r.mode == MODE_CLEAR) begin
         n_clear++;
         known_corners.delete();
      end else if (res.is_new) begin
         n_new++;
         known_corners = {known_corners, r};
      end else if (res.table_full) begin
         n_full++;
      end else begin
         n_hit++;
      end
      pending_indices = {pending_indices, (typed ? typed_rsp : res)};
   endtask

   task automatic idle_burst(input int cycles);
      start <= 1'b0;
      repeat (cycles) @(posedge clock);
   endtask

   task automatic drain_wait();
      start <= 1'b0;
      do @(posedge clock); while (pending_indices.size() != 0);
   endtask

   task automatic maybe_idle();
      if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct)
         idle_burst($urandom_range(1, 14));
   endtask

   function automatic logic [vdh_pkg::REF_W-1:0] odd_ref();
      case ($urandom_range(0, 4))
         0:       return 16'h0000;
         1:       return 16'h0001;
         2:       return 16'hFFFF;
         3:       return 16'h8000;
         default: return vdh_pkg::REF_W'($urandom);
      endcase
   endfunction

   // every key of the run starts at the last slot
   function automatic vdh_pkg::req_type cluster_corner(input int k);
      vdh_pkg::req_type r;
      r.mode       = MODE_CORNER;
      r.pos_ref    = {4'(k), 12'h000};
      r.uv_ref     = vdh_pkg::REF_W'(k + 3);
      r.normal_ref = 16'h0100;
      return r;
   endfunction

   function automatic vdh_pkg::req_type random_corner();
      vdh_pkg::req_type r;
      int               pick;
      r.mode       = MODE_CORNER;
      r.pos_ref    = vdh_pkg::REF_W'($urandom);
      r.uv_ref     = vdh_pkg::REF_W'($urandom);
      r.normal_ref = vdh_pkg::REF_W'($urandom);
      pick         = $urandom_range(0, 99);
      if (pick < 3) begin
         r.mode = MODE_CLEAR;
      end else if (pick < 45 && known_corners.size() != 0) begin
         r = known_corners[$urandom_range(0, known_corners.size() - 1)];
      end else if (pick < 70 && known_corners.size() != 0) begin
         // lands on an occupied start slot with a different key
         r = known_corners[$urandom_range(0, known_corners.size() - 1)];
         case ($urandom_range(0, 2))
            0:       r.uv_ref     = vdh_pkg::REF_W'($urandom);
            1:       r.normal_ref = vdh_pkg::REF_W'($urandom);
            default: r.pos_ref    = r.pos_ref ^ {4'($urandom_range(1, 15)), 12'h000};
         endcase
      end else if (pick < 78) begin
         r.pos_ref    = odd_ref();
         r.uv_ref     = odd_ref();
         r.normal_ref = odd_ref();
      end
      return r;
   endfunction

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles", cycle_count);
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         if (pending_indices.size() == 0) begin
            report_mismatch("response with none pending, vertex_index",
                            rsp_data.vertex_index, '0);
         end else begin
            want = pending_indices.pop_front();
            if (rsp_data.vertex_index !== want.vertex_index)
               report_mismatch("vertex_index", rsp_data.vertex_index, want.vertex_index);
            if (rsp_data.is_new !== want.is_new)
               report_mismatch("is_new", 16'(rsp_data.is_new), 16'(want.is_new));
            if (rsp_data.pos_index !== want.pos_index)
               report_mismatch("pos_index", rsp_data.pos_index, want.pos_index);
            if (rsp_data.uv_index !== want.uv_index)
               report_mismatch("uv_index", rsp_data.uv_index, want.uv_index);
            if (rsp_data.normal_index !== want.normal_index)
               report_mismatch("normal_index", rsp_data.normal_index, want.normal_index);
            if (rsp_data.table_full !== want.table_full)
               report_mismatch("table_full", 16'(rsp_data.table_full),
                               16'(want.table_full));
         end
      end
   end

   initial begin
      vdh_pkg::req_type r;
      int               i;
      cycle_count = 0;
      err_count   = 0;
      n_req       = 0;
      n_new       = 0;
      n_hit       = 0;
      n_full      = 0;
      n_clear     = 0;
      vtx_count   = '0;
      foreach (slot_used[j]) slot_used[j] = 1'b0;
      reset    <= 1'b1;
      start    <= 1'b0;
      req_data <= '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // hand-picked requests; the clearing pass after reset is waited out via busy
      idle_pct = 30;
      for (i = 0; i < NUM_ROWS; i++) begin
         maybe_idle();
         issue(DIRECTED_ROWS[i].req, DIRECTED_ROWS[i].typed, DIRECTED_ROWS[i].rsp);
      end
      drain_wait();

      // long probe chain from the last slot round through slot zero, then hits on it
      idle_pct = 8;
      for (i = 0; i < CLUSTER_ITEMS; i++) begin
         maybe_idle();
         issue(cluster_corner(i), PREDICT, '0);
      end
      for (i = 0; i < CLUSTER_HITS; i++) begin
         maybe_idle();
         issue(cluster_corner($urandom_range(0, CLUSTER_ITEMS - 1)), PREDICT, '0);
      end
      issue('{MODE_CLEAR, 16'h0000, 16'h0000, 16'h0000}, TYPED, '0);
      drain_wait();

      for (i = 0; i < RANDOM_ITEMS; i++) begin
         if (i >= RANDOM_ITEMS - CALM_TAIL)
            idle_pct = 0;
         else if (i % 40 == 0)
            case ($urandom_range(0, 2))
               0:       idle_pct = 0;
               1:       idle_pct = 20;
               default: idle_pct = 50;
            endcase
         r = random_corner();
         if (r.mode == MODE_CLEAR && $urandom_range(0, 1) == 0)
            drain_wait();
         maybe_idle();
         issue(r, PREDICT, '0);
      end

      drain_wait();
      idle_burst(12);

      $display("Ran %0d requests: %0d inserts, %0d hits, %0d full-table misses, %0d clears",
               n_req, n_new, n_hit, n_full, n_clear);
      $display("Covered wrapped references, a %0d-key probe chain past the last slot",
               CLUSTER_ITEMS);
      if (err_count == 0 && pending_indices.size() == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
